// File: sv/mrbc_pkg.sv
package mrbc_pkg;

  localparam int unsigned MAX_DATA_BYTES_DEF = 4;
  // Word gathering is bounded by the 32-bit result
  localparam int unsigned WORD_BYTES         = 4;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [3:0]  FRAME_OVERHEAD = 4'd5;
  localparam logic [3:0]  LEN_MAX        = 4'd15;

  localparam logic [7:0] UNIT_RESET = 8'd1;
  localparam logic [7:0] FUNC_RESET = 8'd1;
  localparam logic [5:0] BITS_RESET = 6'd1;

  typedef enum logic [1:0] {
    REG_UNIT_ADDRESS      = 2'd0,
    REG_EXPECTED_FUNCTION = 2'd1,
    REG_BIT_COUNT         = 2'd2
  } reg_index_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_SHORT      = 3'd1,
    STAT_BAD_UNIT   = 3'd2,
    STAT_BAD_CRC    = 3'd3,
    STAT_BAD_LENGTH = 3'd4,
    STAT_BAD_FUNC   = 3'd5,
    STAT_BAD_COUNT  = 3'd6
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] bit_word;
    logic [3:0]  frame_length;
  } result_t;

  // CRC-16/Modbus, one byte, LSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/modbus_rtu_bit_reply_checker.sv
// Modbus RTU read-bits reply checker. Feed the reply bytes in wire order, one
// request per byte, with frame_end_i high on the last one; the block returns a
// single result per frame (status, masked bit word, frame length). It takes one
// byte every clock cycle unless in_stall_o is raised. An accepted byte is held
// in the input register; when the last byte of a frame moves on, the unrolled
// 8-bit CRC update and the frame checks settle into the result register. A held
// result does not stop byte intake until a second frame end arrives behind it.
// Configuration writes are accepted at any time but must only be made between
// frames; no clearing is needed after reset.
module modbus_rtu_bit_reply_checker #(
  parameter int unsigned MAX_DATA_BYTES = mrbc_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] bit_word_o,
  output logic [3:0]  frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] unit_q, func_q;
  logic [5:0] bits_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       s1_advance;
  logic       in_accept;

  logic              out_valid_q;
  mrbc_pkg::result_t out_q;
  mrbc_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= mrbc_pkg::UNIT_RESET;
      func_q <= mrbc_pkg::FUNC_RESET;
      bits_q <= mrbc_pkg::BITS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mrbc_pkg::REG_UNIT_ADDRESS:      unit_q <= cfg_data_i;
        mrbc_pkg::REG_EXPECTED_FUNCTION: func_q <= cfg_data_i;
        mrbc_pkg::REG_BIT_COUNT:         bits_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // a byte moves on unless it closes a frame while a result is still held
  assign s1_advance = s1_valid_q && (!s1_end_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept || s1_advance) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
      s1_end_q  <= frame_end_i;
    end
  end

  mrbc_frame #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_frame (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (s1_advance),
    .rx_byte_i           (s1_byte_q),
    .frame_end_i         (s1_end_q),
    .unit_address_i      (unit_q),
    .expected_function_i (func_q),
    .bit_count_i         (bits_q),
    .res_o               (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && s1_end_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_end_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign bit_word_o     = out_q.bit_word;
  assign frame_length_o = out_q.frame_length;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_end_q && out_valid_q))
    else $error("input stalled without a blocked frame end");

  a_word_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mrbc_pkg::STAT_OK) |-> (bit_word_o == 32'h0))
    else $error("bit word not cleared on a failed frame");

  a_short_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == mrbc_pkg::STAT_SHORT) ==
                     (frame_length_o < mrbc_pkg::FRAME_OVERHEAD)))
    else $error("short status disagrees with frame length");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && !s1_end_q && !(out_valid_q && out_stall_i)) |=> !out_valid_q)
    else $error("result raised without a frame end");

endmodule

// File: sv/mrbc_frame.sv
module mrbc_frame #(
  parameter int unsigned MAX_DATA_BYTES = mrbc_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_end_i,
  input  logic [7:0]          unit_address_i,
  input  logic [7:0]          expected_function_i,
  input  logic [5:0]          bit_count_i,
  output mrbc_pkg::result_t   res_o
);

  localparam int unsigned GatherBytes =
    (MAX_DATA_BYTES > mrbc_pkg::WORD_BYTES) ? mrbc_pkg::WORD_BYTES : MAX_DATA_BYTES;
  localparam logic [5:0] LimBits = 6'(8 * GatherBytes);

  logic [15:0] crc_q, crc_d;
  logic [3:0]  idx_q, idx_d;
  logic        unit_mis_q, unit_mis_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] data_q, data_d;

  logic [3:0]  len;
  logic [5:0]  n_bits;
  logic [2:0]  n_bytes;
  logic [3:0]  exp_len;
  logic [31:0] mask;

  assign len = (idx_q < mrbc_pkg::LEN_MAX) ? idx_q + 4'd1 : mrbc_pkg::LEN_MAX;

  // Per-byte update of the frame state
  always_comb begin
    crc_d      = mrbc_pkg::crc16_byte(crc_q, rx_byte_i);
    unit_mis_d = unit_mis_q;
    func_d     = func_q;
    count_d    = count_q;
    data_d     = data_q;
    if (idx_q == 4'd0) begin
      unit_mis_d = (rx_byte_i != unit_address_i);
    end
    if (idx_q == 4'd1) begin
      func_d = rx_byte_i;
    end
    if (idx_q == 4'd2) begin
      count_d = rx_byte_i;
    end
    for (int k = 0; k < GatherBytes; k++) begin
      if (idx_q == 4'(3 + k)) begin
        data_d[8*k +: 8] = rx_byte_i;
      end
    end
    idx_d = len;
  end

  assign n_bits  = (bit_count_i > LimBits) ? LimBits : bit_count_i;
  assign n_bytes = 3'((7'(n_bits) + 7'd7) >> 3);
  assign exp_len = 4'(n_bytes) + mrbc_pkg::FRAME_OVERHEAD;
  // shifting by 32 leaves zero, so the full count gives all ones
  assign mask    = ~(32'hFFFF_FFFF << n_bits);

  always_comb begin
    res_o.frame_length = len;
    if (len < mrbc_pkg::FRAME_OVERHEAD) begin
      res_o.status = mrbc_pkg::STAT_SHORT;
    end else if (unit_mis_d) begin
      res_o.status = mrbc_pkg::STAT_BAD_UNIT;
    end else if (crc_d != 16'h0000) begin
      res_o.status = mrbc_pkg::STAT_BAD_CRC;
    end else if (len != exp_len) begin
      res_o.status = mrbc_pkg::STAT_BAD_LENGTH;
    end else if (func_d != expected_function_i) begin
      res_o.status = mrbc_pkg::STAT_BAD_FUNC;
    end else if (count_d != 8'(n_bytes)) begin
      res_o.status = mrbc_pkg::STAT_BAD_COUNT;
    end else begin
      res_o.status = mrbc_pkg::STAT_OK;
    end
    res_o.bit_word = (res_o.status == mrbc_pkg::STAT_OK) ? (data_d & mask) : 32'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= mrbc_pkg::CRC_INIT;
      idx_q      <= 4'd0;
      unit_mis_q <= 1'b0;
      func_q     <= 8'h00;
      count_q    <= 8'h00;
      data_q     <= 32'h0;
    end else if (step_i) begin
      if (frame_end_i) begin
        crc_q      <= mrbc_pkg::CRC_INIT;
        idx_q      <= 4'd0;
        unit_mis_q <= 1'b0;
        func_q     <= 8'h00;
        count_q    <= 8'h00;
        data_q     <= 32'h0;
      end else begin
        crc_q      <= crc_d;
        idx_q      <= idx_d;
        unit_mis_q <= unit_mis_d;
        func_q     <= func_d;
        count_q    <= count_d;
        data_q     <= data_d;
      end
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned GATHER =
    (mrbc_pkg::MAX_DATA_BYTES_DEF > mrbc_pkg::WORD_BYTES) ? mrbc_pkg::WORD_BYTES :
    (mrbc_pkg::MAX_DATA_BYTES_DEF < 1) ? 1 : mrbc_pkg::MAX_DATA_BYTES_DEF;
  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         NUM_PHASES  = 10;
  localparam int         PHASE_BYTES = 48;
  localparam int         LONG_HOLD   = 300;
  localparam int         DRAIN_GAP   = 4;
  localparam int         IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0]        unit;
    logic [7:0]        func;
    logic [7:0]        count;
    logic [7:0]        data;
    logic              ndata;
    logic              bad_crc;
    logic [3:0]        cut;     // 0: whole frame
    mrbc_pkg::result_t exp;
  } dir_row_t;

  // reset settings: unit 1, function 1, one bit
  localparam dir_row_t DIRECTED [7] = '{
    '{8'h01, 8'h01, 8'h01, 8'hA5, 1'b1, 1'b0, 4'd1, '{mrbc_pkg::STAT_SHORT, 32'h0, 4'd1}},
    '{8'h01, 8'h01, 8'h01, 8'hA5, 1'b1, 1'b0, 4'd0, '{mrbc_pkg::STAT_OK, 32'h1, 4'd6}},
    '{8'h00, 8'h01, 8'h01, 8'hA5, 1'b1, 1'b1, 4'd0, '{mrbc_pkg::STAT_BAD_UNIT, 32'h0, 4'd6}},
    '{8'h01, 8'h02, 8'h01, 8'hA5, 1'b1, 1'b1, 4'd0, '{mrbc_pkg::STAT_BAD_CRC, 32'h0, 4'd6}},
    '{8'h01, 8'h03, 8'h00, 8'h00, 1'b0, 1'b0, 4'd0, '{mrbc_pkg::STAT_BAD_LENGTH, 32'h0, 4'd5}},
    '{8'h01, 8'hFF, 8'h00, 8'h5A, 1'b1, 1'b0, 4'd0, '{mrbc_pkg::STAT_BAD_FUNC, 32'h0, 4'd6}},
    '{8'h01, 8'h01, 8'hFF, 8'h00, 1'b1, 1'b0, 4'd0, '{mrbc_pkg::STAT_BAD_COUNT, 32'h0, 4'd6}}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] bit_word_o;
  logic [3:0]  frame_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [7:0]  cfg_data_i  = 8'h00;

  modbus_rtu_bit_reply_checker i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .bit_word_o     (bit_word_o),
    .frame_length_o (frame_length_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow registers
  logic [7:0] cfg_unit = mrbc_pkg::UNIT_RESET;
  logic [7:0] cfg_func = mrbc_pkg::FUNC_RESET;
  logic [5:0] cfg_bits = mrbc_pkg::BITS_RESET;

  // frame state of the reply model
  logic [15:0] frm_crc      = mrbc_pkg::CRC_INIT;
  logic [3:0]  frm_pos      = 4'd0;
  logic        frm_unit_bad = 1'b0;
  logic [7:0]  frm_func     = 8'h00;
  logic [7:0]  frm_count    = 8'h00;
  logic [31:0] frm_data     = 32'h0;

  mrbc_pkg::result_t reply_q[$];
  logic [7:0]        frame_q[$];

  int  fail_count      = 0;
  int  replies_checked = 0;
  int  bytes_sent      = 0;
  int  frames_sent     = 0;
  int  reg_writes      = 0;
  int  status_hits[8]  = '{default: 0};
  int  idle_cycles     = 0;
  int  hold_req        = 0;
  int  hold_ack        = 0;
  int  stall_left      = 0;
  bit  rx_busy         = 1'b1;
  bit  calm            = 1'b0;
  int  gap_odds        = 6;

  // CRC-16/Modbus fed one bit at a time, LSB first
  function automatic logic [15:0] crc16_mb(logic [15:0] c, logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = {1'b0, r[15:1]} ^ mrbc_pkg::CRC_POLY;
      else r = {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic int eff_bits();
    return (int'(cfg_bits) > 8 * GATHER) ? 8 * GATHER : int'(cfg_bits);
  endfunction

  task automatic reply_step(input logic [7:0] b, input logic last,
                            output bit has, output mrbc_pkg::result_t r);
    logic [3:0]  pos;
    logic [3:0]  len;
    logic [31:0] mask;
    int          n;
    int          nb;
    pos = frm_pos;
    has = 1'b0;
    r   = '0;
    frm_crc = crc16_mb(frm_crc, b);
    if (pos == 4'd0) frm_unit_bad = (b != cfg_unit);
    else if (pos == 4'd1) frm_func = b;
    else if (pos == 4'd2) frm_count = b;
    else if (int'(pos) < 3 + GATHER) frm_data |= 32'(b) << (8 * (int'(pos) - 3));
    len = (pos < mrbc_pkg::LEN_MAX) ? pos + 4'd1 : mrbc_pkg::LEN_MAX;
    frm_pos = len;
    if (last) begin
      n  = eff_bits();
      nb = (n + 7) / 8;
      if (len < mrbc_pkg::FRAME_OVERHEAD) r.status = mrbc_pkg::STAT_SHORT;
      else if (frm_unit_bad) r.status = mrbc_pkg::STAT_BAD_UNIT;
      else if (frm_crc != 16'h0) r.status = mrbc_pkg::STAT_BAD_CRC;
      else if (int'(len) != nb + int'(mrbc_pkg::FRAME_OVERHEAD))
        r.status = mrbc_pkg::STAT_BAD_LENGTH;
      else if (frm_func != cfg_func) r.status = mrbc_pkg::STAT_BAD_FUNC;
      else if (int'(frm_count) != nb) r.status = mrbc_pkg::STAT_BAD_COUNT;
      else r.status = mrbc_pkg::STAT_OK;
      mask = (n >= 32) ? 32'hFFFF_FFFF : (32'h1 << n) - 32'h1;
      r.bit_word     = (r.status == mrbc_pkg::STAT_OK) ? (frm_data & mask) : 32'h0;
      r.frame_length = len;
      has = 1'b1;
      frm_crc      = mrbc_pkg::CRC_INIT;
      frm_pos      = 4'd0;
      frm_unit_bad = 1'b0;
      frm_func     = 8'h00;
      frm_count    = 8'h00;
      frm_data     = 32'h0;
    end
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_crc();
    logic [15:0] c;
    c = mrbc_pkg::CRC_INIT;
    foreach (frame_q[i]) c = crc16_mb(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last,
                           output bit has, output mrbc_pkg::result_t r);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_sent++;
    reply_step(b, last, has, r);
  endtask

  // typed: the expected reply is given by the caller rather than the model
  task automatic send_frame(input bit typed, input mrbc_pkg::result_t typed_r);
    bit                has;
    mrbc_pkg::result_t r;
    // sender idles in some frames, not in others
    gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
    foreach (frame_q[i]) begin
      push_byte(frame_q[i], i == frame_q.size() - 1, has, r);
      if (has) reply_q.push_back(typed ? typed_r : r);
    end
    frames_sent++;
  endtask

  task automatic random_frame();
    int         kind;
    int         nb;
    int         nd;
    int         k;
    logic [7:0] u;
    logic [7:0] f;
    logic [7:0] c;
    nb   = (eff_bits() + 7) / 8;
    kind = $urandom_range(0, 99);
    u    = cfg_unit;
    f    = cfg_func;
    c    = 8'(nb);
    nd   = nb;
    frame_q.delete();
    if (kind >= 55 && kind < 62) u ^= 8'($urandom_range(1, 255));
    if (kind >= 62 && kind < 67) f ^= 8'($urandom_range(1, 255));
    if (kind >= 67 && kind < 72) c ^= 8'($urandom_range(1, 255));
    if (kind >= 80 && kind < 86) begin
      do nd = $urandom_range(0, 10); while (nd == nb);
    end
    // well-formed but longer than the counter can hold
    if (kind >= 96) nd = $urandom_range(11, 14);
    if (kind < 86 || kind >= 96) begin
      frame_q = '{u, f, c};
      repeat (nd) frame_q.push_back(data_byte());
      add_crc();
      if (kind >= 72 && kind < 80) begin
        k = $urandom_range(0, frame_q.size() - 1);
        frame_q[k] ^= 8'h01 << $urandom_range(0, 7);
      end
    end else if (kind < 91) begin
      frame_q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : cfg_unit);
      repeat ($urandom_range(0, 3)) frame_q.push_back(data_byte());
    end else begin
      repeat ($urandom_range(5, 22)) frame_q.push_back(data_byte());
    end
    send_frame(1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      mrbc_pkg::REG_UNIT_ADDRESS:      cfg_unit = data;
      mrbc_pkg::REG_EXPECTED_FUNCTION: cfg_func = data;
      mrbc_pkg::REG_BIT_COUNT:         cfg_bits = data[5:0];
      default:                         ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // sender pauses until every reply is back, then lets the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // receiver: short random stalls, quiet stretches, and one long hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && !calm && rx_busy && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
    if ($urandom_range(0, 63) == 0) rx_busy = ~rx_busy;
  end

  always @(posedge clk_i) begin : reply_check
    mrbc_pkg::result_t exp;
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        $display("%0t ns: reply with none pending, status %0d length %0d",
                 $time, status_o, frame_length_o);
        fail_count++;
      end else begin
        exp = reply_q.pop_front();
        replies_checked++;
        status_hits[exp.status]++;
        if (status_o !== exp.status) begin
          $display("%0t ns: status expected %0d, got %0d", $time, exp.status, status_o);
          fail_count++;
        end
        if (bit_word_o !== exp.bit_word) begin
          $display("%0t ns: bit_word expected %h, got %h", $time, exp.bit_word, bit_word_o);
          fail_count++;
        end
        if (frame_length_o !== exp.frame_length) begin
          $display("%0t ns: frame_length expected %0d, got %0d",
                   $time, exp.frame_length, frame_length_o);
          fail_count++;
        end
      end
    end
  end

  logic progress;
  assign progress = (in_valid_i && in_stall_o === 1'b0) ||
                    (out_valid_o === 1'b1 && !out_stall_i) ||
                    (cfg_valid_i && cfg_ready_o === 1'b1);

  always @(posedge clk_i) begin
    if (progress) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int         phase_start;
    int         phase_frames;
    logic [7:0] u;
    logic [7:0] f;
    logic [7:0] b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      frame_q = '{DIRECTED[i].unit, DIRECTED[i].func, DIRECTED[i].count};
      if (DIRECTED[i].ndata) frame_q.push_back(DIRECTED[i].data);
      add_crc();
      if (DIRECTED[i].bad_crc) frame_q[frame_q.size() - 1] ^= 8'h01;
      if (DIRECTED[i].cut != 4'd0) begin
        while (frame_q.size() > DIRECTED[i].cut) void'(frame_q.pop_back());
      end
      send_frame(1'b1, DIRECTED[i].exp);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      u = 8'($urandom);
      f = 8'($urandom_range(1, 2));
      b = {2'($urandom_range(0, 3)), 6'($urandom_range(1, 32))};
      case (p)
        1: begin u = 8'h00; f = 8'h00; b = 8'h00; end
        2: begin u = 8'hFF; f = 8'hFF; b = 8'd32; end
        3: begin u = 8'h11; f = 8'h02; b = 8'hFF; end   // 63, clamps to 32
        4: b = {2'($urandom_range(0, 3)), 6'd33};
        5: b = 8'd8;
        6: begin f = 8'($urandom); b = 8'd9; end
        7: b = 8'd16;
        9: begin u = 8'hF7; f = 8'h01; b = 8'd25; end
        default: ;
      endcase
      if (p != 0) begin
        write_reg(mrbc_pkg::REG_UNIT_ADDRESS, u);
        write_reg(mrbc_pkg::REG_EXPECTED_FUNCTION, f);
        write_reg(mrbc_pkg::REG_BIT_COUNT, b);
        if (p == 7) write_reg(REG_SPARE, 8'($urandom));
      end
      if (p == NUM_PHASES - 1) calm <= 1'b1;
      phase_start  = bytes_sent;
      phase_frames = 0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // hold replies back long enough for the input to back up
        if (p == 2 && phase_frames == 2) hold_req <= hold_req + 1;
        random_frame();
        phase_frames++;
      end
      drain();
    end

    $display("Ran %0d bytes in %0d frames, %0d replies checked, %0d register writes",
             bytes_sent, frames_sent, replies_checked, reg_writes);
    $display("Replies: ok %0d short %0d unit %0d crc %0d length %0d function %0d count %0d",
             status_hits[mrbc_pkg::STAT_OK], status_hits[mrbc_pkg::STAT_SHORT],
             status_hits[mrbc_pkg::STAT_BAD_UNIT], status_hits[mrbc_pkg::STAT_BAD_CRC],
             status_hits[mrbc_pkg::STAT_BAD_LENGTH], status_hits[mrbc_pkg::STAT_BAD_FUNC],
             status_hits[mrbc_pkg::STAT_BAD_COUNT]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mrbc_pkg.sv
sv/mrbc_frame.sv
sv/modbus_rtu_bit_reply_checker.sv
test/tb_top.sv
